/* sv/terrain_vertex_shader_defines.svh */
// assertion macros for the terrain vertex shader
// define NO_ASSERTIONS to compile them out
`ifndef TERRAIN_VERTEX_SHADER_DEFINES_SVH
`define TERRAIN_VERTEX_SHADER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TVS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TVS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TVS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TVS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/tvs_pkg.sv */
// shared types, constants and vertex arithmetic of the terrain vertex shader
// no dependencies
package tvs_pkg;

  localparam logic [7:0] GRID_CELLS = 8'd128;

  typedef struct packed {
    logic signed [11:0] height_sample;
  } tvs_in_t;

  typedef struct packed {
    logic [10:0] screen_x;
    logic [14:0] screen_y_sixteenths;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        under_water;
    logic        last_in_run;
  } tvs_out_t;

  typedef struct packed {
    logic [7:0] land_red;
    logic [7:0] land_green;
    logic [7:0] land_blue;
    logic [7:0] water_red;
    logic [7:0] water_green;
    logic [7:0] water_blue;
  } tvs_colour_cfg_t;

  typedef enum logic [2:0] {
    REG_LAND_RED    = 3'd0,
    REG_LAND_GREEN  = 3'd1,
    REG_LAND_BLUE   = 3'd2,
    REG_WATER_RED   = 3'd3,
    REG_WATER_GREEN = 3'd4,
    REG_WATER_BLUE  = 3'd5
  } tvs_reg_t;

  // q0.8 light from the row slope, clamped to 26..205
  function automatic logic [7:0] light_of(input logic signed [12:0] slope);
    logic signed [13:0] t;
    logic [7:0] lt;
    t = {slope[12], slope} + 14'sd192;
    if (t < 14'sd52) begin
      lt = 8'd26;
    end else if (t >= 14'sd410) begin
      lt = 8'd205;
    end else begin
      lt = t[8:1];
    end
    return lt;
  endfunction

  function automatic tvs_out_t make_vertex(input logic [7:0] col,
                                           input logic [7:0] row,
                                           input logic signed [11:0] h,
                                           input logic [7:0] light,
                                           input tvs_colour_cfg_t cfg,
                                           input logic last);
    logic [10:0] sx;
    logic [14:0] sy;
    logic [15:0] pr;
    logic [15:0] pg;
    logic [15:0] pb;
    logic        water;
    tvs_out_t    v;
    // positions wrap to the field widths
    sx = 11'd5 * ({3'b0, col} - {3'b0, row}) + 11'd640;
    sy = 15'd40 * ({7'b0, col} + {7'b0, row}) - {{3{h[11]}}, h} + 15'd4096;
    water = (h <= -12'sd256);
    pr = {8'b0, light} * {8'b0, cfg.land_red};
    pg = {8'b0, light} * {8'b0, cfg.land_green};
    pb = {8'b0, light} * {8'b0, cfg.land_blue};
    v.screen_x            = sx;
    v.screen_y_sixteenths = sy;
    v.red_out             = water ? cfg.water_red   : pr[15:8];
    v.green_out           = water ? cfg.water_green : pg[15:8];
    v.blue_out            = water ? cfg.water_blue  : pb[15:8];
    v.under_water         = water;
    v.last_in_run         = last;
    return v;
  endfunction

endpackage

/* sv/tvs_stream_if.sv */
// valid/ready channels of the terrain vertex shader
// depends on tvs_pkg for the payload types
interface tvs_in_if import tvs_pkg::*; ();
  logic    valid;
  logic    ready;
  tvs_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tvs_out_if import tvs_pkg::*; ();
  logic     valid;
  logic     ready;
  tvs_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/terrain_vertex_shader.sv */
// terrain vertex shader: heightmap samples in, shaded isometric vertices out
// depends on tvs_pkg, tvs_stream_if and terrain_vertex_shader_defines.svh
//
// in_ch carries one height sample per item in raster order; rows and columns
// are counted internally. out_ch carries one vertex per item. each vertex is
// held until its right neighbour arrives, so the first sample of a row gives
// no vertex, the middle ones give one and the last column gives two.
// the shading of a sample is done in the cycle it is accepted and written to
// a two-entry output queue, whose head register drives out_ch. one sample is
// taken per cycle while out_ch is ready, the last column included: a vertex
// leaving the queue in the same cycle makes room for the pair.
// when out_ch stalls the queue holds its vertices and in_ch.ready drops as
// soon as the queue, less any vertex leaving this cycle, has no room for
// what the next sample will produce.
// the colour registers sit on an apb-style port, byte address 4 per register;
// write them only while no samples are in flight.
// reset empties the queue, zeroes the grid counters and the held height and
// loads the default land (white) and water (blue) colours.
`include "terrain_vertex_shader_defines.svh"

module terrain_vertex_shader import tvs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  tvs_in_if.sink       in_ch,
  tvs_out_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  tvs_colour_cfg_t cfg_r;

  logic signed [11:0] prev_r;
  logic [7:0]         col_r;
  logic [7:0]         row_r;

  tvs_out_t q_r [2];
  tvs_out_t q_nxt [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] base;

  logic        is_first;
  logic        is_last;
  logic [1:0]  need;
  logic        in_acc;
  logic        pop;
  logic        cfg_wr;
  logic [7:0]  light;
  tvs_out_t    vert_a;
  tvs_out_t    vert_b;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.land_red    <= 8'd255;
      cfg_r.land_green  <= 8'd255;
      cfg_r.land_blue   <= 8'd255;
      cfg_r.water_red   <= 8'd0;
      cfg_r.water_green <= 8'd0;
      cfg_r.water_blue  <= 8'd255;
    end else if (cfg_wr) begin
      case (tvs_reg_t'(paddr[4:2]))
        REG_LAND_RED:    cfg_r.land_red    <= pwdata[7:0];
        REG_LAND_GREEN:  cfg_r.land_green  <= pwdata[7:0];
        REG_LAND_BLUE:   cfg_r.land_blue   <= pwdata[7:0];
        REG_WATER_RED:   cfg_r.water_red   <= pwdata[7:0];
        REG_WATER_GREEN: cfg_r.water_green <= pwdata[7:0];
        REG_WATER_BLUE:  cfg_r.water_blue  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (tvs_reg_t'(paddr[4:2]))
      REG_LAND_RED:    prdata = {24'b0, cfg_r.land_red};
      REG_LAND_GREEN:  prdata = {24'b0, cfg_r.land_green};
      REG_LAND_BLUE:   prdata = {24'b0, cfg_r.land_blue};
      REG_WATER_RED:   prdata = {24'b0, cfg_r.water_red};
      REG_WATER_GREEN: prdata = {24'b0, cfg_r.water_green};
      REG_WATER_BLUE:  prdata = {24'b0, cfg_r.water_blue};
      default:         prdata = 32'b0;
    endcase
  end

  // vertex shading
  assign is_first = (col_r == 8'd0);
  assign is_last  = (col_r >= GRID_CELLS);
  assign need     = is_first ? 2'd0 : (is_last ? 2'd2 : 2'd1);

  assign light  = light_of({prev_r[11], prev_r} - {in_ch.payload.height_sample[11],
                                                    in_ch.payload.height_sample});
  assign vert_a = make_vertex(col_r - 8'd1, row_r, prev_r, light, cfg_r, !is_last);
  assign vert_b = make_vertex(col_r, row_r, in_ch.payload.height_sample, light, cfg_r,
                              1'b1);

  // handshakes
  assign in_ch.ready    = ({1'b0, cnt_r} + {1'b0, need}) <= (3'd2 + {2'b0, pop});
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = (cnt_r != 2'd0);
  assign out_ch.payload = q_r[0];
  assign pop            = out_ch.valid && out_ch.ready;

  // output queue
  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    if (pop) begin
      q_nxt[0] = q_r[1];
      base = cnt_r - 2'd1;
    end else begin
      base = cnt_r;
    end
    cnt_nxt = base;
    if (in_acc && !is_first) begin
      q_nxt[base[0]] = vert_a;
      if (is_last) begin
        q_nxt[1] = vert_b;
      end
      cnt_nxt = base + need;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      prev_r <= 12'sd0;
      col_r  <= 8'd0;
      row_r  <= 8'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        prev_r <= in_ch.payload.height_sample;
        if (is_first) begin
          col_r <= 8'd1;
        end else if (is_last) begin
          col_r <= 8'd0;
          row_r <= (row_r >= GRID_CELLS) ? 8'd0 : row_r + 8'd1;
        end else begin
          col_r <= col_r + 8'd1;
        end
      end
    end
  end

  `TVS_ASSERT(a_row_end_fills_queue, clk, rst_n, in_acc && is_last |=> cnt_r == 2'd2, "row end did not leave two vertices queued")
  `TVS_ASSERT(a_held_vertex_has_partner, clk, rst_n, out_ch.valid && !q_r[0].last_in_run |-> cnt_r == 2'd2, "non-final vertex queued alone")
  `TVS_ASSERT(a_row_moves_at_row_end, clk, rst_n, !(in_acc && is_last) |=> $stable(row_r), "row counter moved mid row")
  `TVS_ASSERT(a_first_column_silent, clk, rst_n, in_acc && is_first |=> col_r == 8'd1 && cnt_r == $past(cnt_r) - {1'b0, $past(pop)}, "first column produced a vertex")

endmodule
